/* rtl/bblc_pkg.sv */
// shared types and register codes for the bayer black level correction block
// no dependencies

package bblc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_LINEAR_MODE = 3'd1,
    REG_CFA_PATTERN = 3'd2,
    REG_PIXEL_DEPTH = 3'd3,
    REG_BLUE        = 3'd4,
    REG_GREEN_BLUE  = 3'd5,
    REG_GREEN_RED   = 3'd6,
    REG_RED         = 3'd7
  } bblc_reg_e;

  // bayer channels, also the index into the level registers
  typedef enum logic [1:0] {
    CH_B  = 2'd0,
    CH_GB = 2'd1,
    CH_GR = 2'd2,
    CH_R  = 2'd3
  } bblc_chan_e;

  localparam int unsigned PixW     = 16;
  localparam int unsigned MaxDepth = 16;
  localparam int unsigned Latency  = 20;

  // per-pixel sideband that travels down the pipeline
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic [PixW-1:0] val;
    logic [PixW-1:0] range;
    logic            en;
    logic            lin;
    logic            ovf;
    logic            eor;
    logic            eof;
  } bblc_side_t;

endpackage

/* rtl/bayer_black_level_correction_top.sv */
// top level of the bayer black level correction pipeline
// throughput: one pixel per cycle; busy_o stays low, the receiver cannot stall
// stages: channel select and subtract, multiply, overflow check,
// 16 divider stages, output select and clamp
// reset: async active low, clears valid bits and config regs; pixel_depth resets to 12

module bayer_black_level_correction_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] pixel_in_i,
  input  logic        row_odd_i,
  input  logic        col_odd_i,
  input  logic        end_of_row_i,
  input  logic        end_of_frame_i,
  output logic        valid_o,
  output logic [15:0] pixel_out_o,
  output logic        row_done_o,
  output logic        frame_done_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned W = bblc_pkg::PixW;

  // configuration registers
  logic        enable_q;
  logic        linear_q;
  logic [1:0]  cfa_q;
  logic [4:0]  depth_q;
  logic [31:0] levels_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      linear_q    <= 1'b0;
      cfa_q       <= 2'd0;
      depth_q     <= 5'd12;
      levels_q[0] <= '0;
      levels_q[1] <= '0;
      levels_q[2] <= '0;
      levels_q[3] <= '0;
    end else if (cfg_we_i) begin
      case (bblc_pkg::bblc_reg_e'(cfg_idx_i))
        bblc_pkg::REG_ENABLE:      enable_q <= cfg_wdata_i[0];
        bblc_pkg::REG_LINEAR_MODE: linear_q <= cfg_wdata_i[0];
        bblc_pkg::REG_CFA_PATTERN: cfa_q    <= cfg_wdata_i[1:0];
        bblc_pkg::REG_PIXEL_DEPTH: depth_q  <= cfg_wdata_i[4:0];
        bblc_pkg::REG_BLUE:        levels_q[bblc_pkg::CH_B]  <= cfg_wdata_i;
        bblc_pkg::REG_GREEN_BLUE:  levels_q[bblc_pkg::CH_GB] <= cfg_wdata_i;
        bblc_pkg::REG_GREEN_RED:   levels_q[bblc_pkg::CH_GR] <= cfg_wdata_i;
        bblc_pkg::REG_RED:         levels_q[bblc_pkg::CH_R]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // stage 1: channel select, offset subtract, divisor and range
  logic [1:0]   chan;
  logic [31:0]  lv;
  logic [W-1:0] offset;
  logic [W-1:0] sat;
  logic [4:0]   depth_clamped;

  // the channel is the position code xor the pattern code
  assign chan   = cfa_q ^ {row_odd_i, col_odd_i};
  assign lv     = levels_q[chan];
  assign offset = lv[W-1:0];
  assign sat    = lv[2*W-1:W];
  assign depth_clamped = (depth_q > 5'(bblc_pkg::MaxDepth)) ?
                         5'(bblc_pkg::MaxDepth) : depth_q;

  logic                 s1_vld_q;
  bblc_pkg::bblc_side_t s1_side_q, s1_side_d;
  logic [W-1:0]         s1_div_q, s1_div_d;

  always_comb begin
    s1_side_d       = '0;
    s1_side_d.pix   = pixel_in_i;
    s1_side_d.val   = (pixel_in_i > offset) ? pixel_in_i - offset : '0;
    s1_side_d.range = ~({W{1'b1}} << depth_clamped);
    s1_side_d.en    = enable_q;
    s1_side_d.lin   = linear_q;
    s1_side_d.eor   = end_of_row_i;
    s1_side_d.eof   = end_of_frame_i;
    s1_div_d        = (sat > offset) ? sat - offset : W'(1);
  end

  // stage 2: product val * range
  logic                 s2_vld_q;
  bblc_pkg::bblc_side_t s2_side_q;
  logic [W-1:0]         s2_div_q;
  logic [2*W-1:0]       s2_prod_q, s2_prod_d;

  assign s2_prod_d = {{W{1'b0}}, s1_side_q.val} * {{W{1'b0}}, s1_side_q.range};

  // stage 3: flag a quotient over 16 bits; linear mode clamps it to range
  logic                 s3_vld_q;
  bblc_pkg::bblc_side_t s3_side_q, s3_side_d;
  logic [W-1:0]         s3_div_q;
  logic [2*W-1:0]       s3_prod_q;

  always_comb begin
    s3_side_d     = s2_side_q;
    s3_side_d.ovf = (s2_prod_q[2*W-1:W] >= s2_div_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= s1_side_d;
    s1_div_q  <= s1_div_d;
    s2_side_q <= s1_side_q;
    s2_div_q  <= s1_div_q;
    s2_prod_q <= s2_prod_d;
    s3_side_q <= s3_side_d;
    s3_div_q  <= s2_div_q;
    s3_prod_q <= s2_prod_q;
  end

  // divider stages
  logic                 dv_vld;
  logic [W-1:0]         dv_quot;
  bblc_pkg::bblc_side_t dv_side;

  bblc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s3_vld_q),
    .dividend_i (s3_prod_q),
    .divisor_i  (s3_div_q),
    .side_i     (s3_side_q),
    .valid_o    (dv_vld),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  // output select and clamp
  logic [W-1:0] scaled;
  logic [W-1:0] pix_d;

  always_comb begin
    scaled = dv_side.lin ? (dv_side.ovf ? dv_side.range : dv_quot) : dv_side.val;
    if (!dv_side.en) begin
      pix_d = dv_side.pix;
    end else if (scaled > dv_side.range) begin
      pix_d = dv_side.range;
    end else begin
      pix_d = scaled;
    end
  end

  logic         valid_q;
  logic [W-1:0] pix_q;
  logic         eor_q;
  logic         eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
    eor_q <= dv_side.eor;
    eof_q <= dv_side.eof;
  end

  assign valid_o      = valid_q;
  assign pixel_out_o  = pix_q;
  assign row_done_o   = eor_q;
  assign frame_done_o = eof_q;

endmodule

/* rtl/bblc_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on bblc_pkg; expects dividend[31:16] < divisor for a valid quotient

module bblc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [2*bblc_pkg::PixW-1:0]   dividend_i,
  input  logic [bblc_pkg::PixW-1:0]     divisor_i,
  input  bblc_pkg::bblc_side_t          side_i,
  output logic                          valid_o,
  output logic [bblc_pkg::PixW-1:0]     quot_o,
  output bblc_pkg::bblc_side_t          side_o
);

  localparam int unsigned W      = bblc_pkg::PixW;
  localparam int unsigned Stages = bblc_pkg::PixW;

  logic                 vld_q  [Stages];
  logic [W-1:0]         rem_q  [Stages];
  logic [W-1:0]         low_q  [Stages];
  logic [W-1:0]         quo_q  [Stages];
  logic [W-1:0]         div_q  [Stages];
  bblc_pkg::bblc_side_t side_q [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic                 src_vld;
    logic [W-1:0]         src_rem;
    logic [W-1:0]         src_low;
    logic [W-1:0]         src_quo;
    logic [W-1:0]         src_div;
    bblc_pkg::bblc_side_t src_side;
    logic [W:0]           trial;
    logic [W:0]           diff;
    logic                 ge;

    if (k == 0) begin : g_first
      assign src_vld  = valid_i;
      assign src_rem  = dividend_i[2*W-1:W];
      assign src_low  = dividend_i[W-1:0];
      assign src_quo  = '0;
      assign src_div  = divisor_i;
      assign src_side = side_i;
    end else begin : g_next
      assign src_vld  = vld_q[k-1];
      assign src_rem  = rem_q[k-1];
      assign src_low  = low_q[k-1];
      assign src_quo  = quo_q[k-1];
      assign src_div  = div_q[k-1];
      assign src_side = side_q[k-1];
    end

    // shift in the next dividend bit and try the subtract
    assign trial = {src_rem, src_low[W-1]};
    assign diff  = trial - {1'b0, src_div};
    assign ge    = (trial >= {1'b0, src_div});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? diff[W-1:0] : trial[W-1:0];
      low_q[k]  <= {src_low[W-2:0], 1'b0};
      quo_q[k]  <= {src_quo[W-2:0], ge};
      div_q[k]  <= src_div;
      side_q[k] <= src_side;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign quot_o  = quo_q[Stages-1];
  assign side_o  = side_q[Stages-1];

endmodule

/* rtl/bblc_checker.sv */
// port-level checks for the bayer black level correction top level
// depends on bblc_pkg; bound to bayer_black_level_correction_top

module bblc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        end_of_row_i,
  input logic        end_of_frame_i,
  input logic        valid_o,
  input logic        row_done_o,
  input logic        frame_done_o
);

  localparam int unsigned Lat = bblc_pkg::Latency;

  // the pipeline never holds off a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  // every accepted pixel comes out after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat valid_o)
    else $error("result missing after latency");

  // no result without a transfer at the matching earlier cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, Lat))
    else $error("unexpected result strobe");

  // end marks travel with their pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (row_done_o == $past(end_of_row_i, Lat)) &&
                (frame_done_o == $past(end_of_frame_i, Lat)))
    else $error("end marks out of step");

endmodule

bind bayer_black_level_correction_top bblc_checker u_bblc_checker (.*);

/* bench/tb_top.sv */
// self-checking bench for bayer_black_level_correction_top: directed corner pixels,
// then random register settings with framed pixel streams, checked against a predictor
// depends on bblc_pkg and the block's rtl only
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CycleLimit      = 200000;
  localparam int unsigned SettingsPerMode = 10;
  localparam int unsigned PixPerSetting   = 61;

  typedef struct packed {
    logic [15:0] pix;
    logic        row_done;
    logic        frame_done;
  } corr_pix_t;

  class bblc_scoreboard;
    logic        en;
    logic        lin;
    logic [1:0]  cfa;
    logic [4:0]  depth;
    logic [31:0] levels [4];
    corr_pix_t   corrected_q [$];
    int unsigned noted;
    int unsigned checked;
    int unsigned mismatches;

    function new();
      en    = 1'b0;
      lin   = 1'b0;
      cfa   = 2'd0;
      depth = 5'd12;
      foreach (levels[i]) levels[i] = '0;
      noted      = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void set_reg(bblc_pkg::bblc_reg_e idx, logic [31:0] data);
      case (idx)
        bblc_pkg::REG_ENABLE:      en    = data[0];
        bblc_pkg::REG_LINEAR_MODE: lin   = data[0];
        bblc_pkg::REG_CFA_PATTERN: cfa   = data[1:0];
        bblc_pkg::REG_PIXEL_DEPTH: depth = data[4:0];
        default:         levels[int'(idx) - int'(bblc_pkg::REG_BLUE)] = data;
      endcase
    endfunction

    // works out the corrected pixel for an accepted input transfer
    function void note_pixel(logic [15:0] pix, logic rodd, logic codd, logic eor, logic eof);
      bblc_pkg::bblc_chan_e ch;
      logic [15:0] offs;
      logic [15:0] sat;
      logic [15:0] val;
      logic [16:0] rng;
      logic [16:0] diff;
      logic [31:0] quo;
      corr_pix_t   exp_pix;
      exp_pix.pix        = pix;
      exp_pix.row_done   = eor;
      exp_pix.frame_done = eof;
      if (en) begin
        // every pattern is the bggr order with the parity bits flipped
        ch   = bblc_pkg::bblc_chan_e'({rodd, codd} ^ cfa);
        offs = levels[ch][15:0];
        sat  = levels[ch][31:16];
        diff = (sat > offs) ? 17'(sat - offs) : 17'd1;
        rng  = (17'd1 << ((depth > bblc_pkg::MaxDepth) ? bblc_pkg::MaxDepth : depth))
               - 17'd1;
        val  = (pix > offs) ? pix - offs : 16'd0;
        quo  = 32'(val);
        if (lin) quo = (32'(val) * 32'(rng)) / 32'(diff);
        if (quo > 32'(rng)) quo = 32'(rng);
        exp_pix.pix = quo[15:0];
      end
      corrected_q.push_back(exp_pix);
      noted++;
    endfunction

    function void check_pixel(logic [15:0] pix, logic rd, logic fd);
      corr_pix_t exp_pix;
      if (corrected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result pixel %h row_done %b frame_done %b",
                   $realtime, pix, rd, fd);
        return;
      end
      exp_pix = corrected_q.pop_front();
      checked++;
      if (exp_pix.pix !== pix || exp_pix.row_done !== rd || exp_pix.frame_done !== fd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pixel %h/%b/%b expected, got %h/%b/%b", $realtime,
                   exp_pix.pix, exp_pix.row_done, exp_pix.frame_done, pix, rd, fd);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [15:0] pixel_in_i;
  logic        row_odd_i;
  logic        col_odd_i;
  logic        end_of_row_i;
  logic        end_of_frame_i;
  logic        valid_o;
  logic [15:0] pixel_out_o;
  logic        row_done_o;
  logic        frame_done_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  bblc_scoreboard sb;
  int unsigned    cycles;
  int unsigned    idle_pct;
  int unsigned    setting_cnt;
  logic [15:0]    cur_mask;
  int unsigned    col_cnt;
  int unsigned    row_cnt;
  int unsigned    row_len;
  int unsigned    frame_rows;

  bayer_black_level_correction_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .pixel_in_i     (pixel_in_i),
    .row_odd_i      (row_odd_i),
    .col_odd_i      (col_odd_i),
    .end_of_row_i   (end_of_row_i),
    .end_of_frame_i (end_of_frame_i),
    .valid_o        (valid_o),
    .pixel_out_o    (pixel_out_o),
    .row_done_o     (row_done_o),
    .frame_done_o   (frame_done_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // monitor: inputs are driven after the edge, so these are the values the block saw
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else if (rst_ni) begin
      if (valid_o) sb.check_pixel(pixel_out_o, row_done_o, frame_done_o);
      if (start_i && !busy_o)
        sb.note_pixel(pixel_in_i, row_odd_i, col_odd_i, end_of_row_i, end_of_frame_i);
    end
  end

  task automatic send_pixel(logic [15:0] pix, logic rodd, logic codd, logic eor, logic eof);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    pixel_in_i     <= pix;
    row_odd_i      <= rodd;
    col_odd_i      <= codd;
    end_of_row_i   <= eor;
    end_of_frame_i <= eof;
    taken = 1'b0;
    // busy_o is stable at the falling edge, so the transfer is known before the next edge
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every corrected pixel has come out
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (sb.corrected_q.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(bblc_pkg::bblc_reg_e idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic en, logic lin, logic [1:0] cfa, logic [4:0] depth,
                               logic [31:0] lv_b, logic [31:0] lv_gb,
                               logic [31:0] lv_gr, logic [31:0] lv_r);
    drain();
    write_reg(bblc_pkg::REG_ENABLE, 32'(en));
    write_reg(bblc_pkg::REG_LINEAR_MODE, 32'(lin));
    write_reg(bblc_pkg::REG_CFA_PATTERN, 32'(cfa));
    write_reg(bblc_pkg::REG_PIXEL_DEPTH, 32'(depth));
    write_reg(bblc_pkg::REG_BLUE, lv_b);
    write_reg(bblc_pkg::REG_GREEN_BLUE, lv_gb);
    write_reg(bblc_pkg::REG_GREEN_RED, lv_gr);
    write_reg(bblc_pkg::REG_RED, lv_r);
    cfg_we_i <= 1'b0;
    cur_mask = (depth > bblc_pkg::MaxDepth) ? 16'hFFFF : 16'((17'd1 << depth) - 17'd1);
    setting_cnt++;
  endtask

  task automatic random_setting();
    logic [4:0]  depth;
    logic [15:0] mask;
    logic [15:0] offs;
    logic [15:0] sat;
    logic [31:0] lv [4];
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0: depth = 5'd0;
          1: depth = 5'd1;
          2: depth = 5'd16;
          default: depth = 5'd31;
        endcase
      end
      1: depth = 5'($urandom_range(31, 17));
      default: depth = 5'($urandom_range(16, 1));
    endcase
    mask = (depth > bblc_pkg::MaxDepth) ? 16'hFFFF : 16'((17'd1 << depth) - 17'd1);
    foreach (lv[i]) begin
      offs = 16'($urandom_range(int'(mask) / 4));
      case ($urandom_range(3))
        0: lv[i] = $urandom;
        1: begin
          // saturation at or below the offset falls back to a divisor of one
          sat   = 16'($urandom_range(int'(offs)));
          lv[i] = {sat, offs};
        end
        default: begin
          sat   = 16'($urandom_range(int'(mask), int'(offs)));
          lv[i] = {sat, offs};
        end
      endcase
    end
    apply_setting($urandom_range(3) != 0, 1'($urandom_range(1)), 2'($urandom_range(3)),
                  depth, lv[0], lv[1], lv[2], lv[3]);
  endtask

  // rows and frames of random size with matching parity, plus some stray pixels
  task automatic send_stream(int unsigned n);
    logic [15:0] pix;
    logic        rodd;
    logic        codd;
    logic        eor;
    logic        eof;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: pix = 16'($urandom);
        3: begin
          case ($urandom_range(2))
            0: pix = 16'h0000;
            1: pix = 16'hFFFF;
            default: pix = cur_mask;
          endcase
        end
        default: pix = 16'($urandom) & cur_mask;
      endcase
      if ($urandom_range(9) == 0) begin
        rodd = 1'($urandom_range(1));
        codd = 1'($urandom_range(1));
        eor  = 1'($urandom_range(1));
        eof  = 1'($urandom_range(1));
      end else begin
        rodd = row_cnt[0];
        codd = col_cnt[0];
        eor  = (col_cnt == row_len - 1);
        eof  = eor && (row_cnt == frame_rows - 1);
        if (eor) begin
          col_cnt = 0;
          if (eof) begin
            row_cnt    = 0;
            row_len    = $urandom_range(9, 2);
            frame_rows = $urandom_range(4, 2);
          end else begin
            row_cnt++;
          end
        end else begin
          col_cnt++;
        end
      end
      send_pixel(pix, rodd, codd, eor, eof);
    end
  endtask

  initial begin
    sb             = new();
    cycles         = 0;
    idle_pct       = 0;
    setting_cnt    = 0;
    cur_mask       = 16'h0FFF;
    col_cnt        = 0;
    row_cnt        = 0;
    row_len        = 4;
    frame_rows     = 2;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    pixel_in_i     <= '0;
    row_odd_i      <= 1'b0;
    col_odd_i      <= 1'b0;
    end_of_row_i   <= 1'b0;
    end_of_frame_i <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= bblc_pkg::REG_ENABLE;
    cfg_wdata_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset the block is off: pixels pass through without any clamp
    send_pixel(16'h0000, 1'b0, 1'b0, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);

    // enable only, so the reset depth of twelve bits sets the clamp
    drain();
    write_reg(bblc_pkg::REG_ENABLE, 32'd1);
    cfg_we_i <= 1'b0;
    send_pixel(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0);
    send_pixel(16'h0FFF, 1'b1, 1'b0, 1'b0, 1'b0);
    send_pixel(16'h1000, 1'b1, 1'b1, 1'b1, 1'b1);

    // rggb, linear, full depth: pixel at offset, full span, saturation below offset,
    // offset at the top of the range
    apply_setting(1'b1, 1'b1, 2'd3, 5'd16, {16'h1000, 16'h0100}, {16'h0040, 16'h0080},
                  {16'hFFFF, 16'h0000}, {16'hFFFF, 16'hFFFF});
    send_pixel(16'h0100, 1'b1, 1'b1, 1'b0, 1'b0);
    send_pixel(16'h1000, 1'b1, 1'b1, 1'b0, 1'b0);
    send_pixel(16'h00C0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1);

    // zero depth clamps every corrected pixel to zero
    apply_setting(1'b1, 1'b0, 2'd1, 5'd0, '0, '0, '0, '0);
    send_pixel(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
    send_pixel(16'h0001, 1'b1, 1'b1, 1'b1, 1'b1);

    // depth beyond sixteen acts as sixteen
    apply_setting(1'b1, 1'b1, 2'd2, 5'd31, {16'h8000, 16'h0010}, 32'hFFFF_0000,
                  32'hFFFF_0000, 32'hFFFF_0000);
    send_pixel(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0);
    send_pixel(16'h1234, 1'b0, 1'b0, 1'b1, 1'b0);

    // one bit depth
    apply_setting(1'b1, 1'b0, 2'd0, 5'd1, '0, '0, '0, '0);
    send_pixel(16'h0001, 1'b0, 1'b1, 1'b0, 1'b0);
    send_pixel(16'h0002, 1'b1, 1'b1, 1'b1, 1'b1);

    for (int unsigned mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 20 : (mode == 1) ? 50 : 0;
      for (int unsigned s = 0; s < SettingsPerMode; s++) begin
        random_setting();
        send_stream(PixPerSetting);
      end
    end

    drain();
    repeat (bblc_pkg::Latency + 4) @(posedge clk_i);
    $display("ran %0d pixels through %0d register settings, sender gaps 0/20/50 percent",
             sb.noted, setting_cnt + 1);
    $display("%0d results checked, %0d mismatches, %0d results missing",
             sb.checked, sb.mismatches, sb.corrected_q.size());
    if (sb.mismatches == 0 && sb.corrected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bblc_pkg.sv
rtl/bblc_div.sv
rtl/bayer_black_level_correction_top.sv
rtl/bblc_checker.sv
bench/tb_top.sv
